### sv/srsw_pkg.sv
package srsw_pkg;

   typedef enum logic [1:0] {
      OP_SEND    = 2'd0,
      OP_ACK     = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_STOP    = 2'd2,
      TMR_RESTART = 2'd3
   } timer_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SLIDE = 2'b10
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic mark;
   } cell_ctrl_type;

endpackage

### sv/selective_repeat_sender_window_top.sv
// selective-repeat arq sender window
// input channel (req_*): one beat per event: send a message word, an ack
// arrived (with its checksum verdict) or a timer expired for a sequence number.
// result channel (rsp_*): exactly one beat per input beat, carrying the packet
// to emit (if any), the timer action and the window status after the event.
// the window is a row of cells ordered by offset from the base; cell 0 holds
// the oldest outstanding packet. an ack marks its cell, then the row shifts
// toward cell 0 by one cell per cycle while the head cell is acknowledged.
// an event is first taken into the pending registers; the row then shifts
// while the head cell is acknowledged (once per freed head entry, at most
// the window capacity), and only then is the result copied into the output
// register. one event is in flight at a time: the next is not taken until
// the result of the last one has been published.
// the result sits in an output register; the next event is taken as soon as
// that register is free or being drained in the same cycle.
// if the receiver stalls, the result holds and req_ready stays low until it
// is taken. reset (synchronous) empties the window: base and next sequence
// numbers return to zero and all acknowledge marks clear.
module selective_repeat_sender_window_top #(
   parameter int WINDOW       = 4,
   parameter int SEQ_SPACE    = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_seq_number,
   input  logic        req_check_ok,
   input  logic [31:0] req_message_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_packet_out,
   output logic [2:0]  rsp_packet_seq,
   output logic [31:0] rsp_packet_data,
   output logic [1:0]  rsp_timer_action,
   output logic        rsp_accepted,
   output logic        rsp_window_full,
   output logic [2:0]  rsp_window_base,
   output logic [2:0]  rsp_outstanding
);
   import srsw_pkg::*;

   localparam int CAP   = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE;
   localparam int SEQ_W = $clog2(SEQ_SPACE);
   localparam int CNT_W = $clog2(CAP + 1);
   localparam int PW    = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
   localparam int AW    = (SEQ_W > 3) ? SEQ_W : 3;
   localparam int CW    = ((AW > CNT_W) ? AW : CNT_W) + 1;

   state_type        state_ff, state_in;
   logic [SEQ_W-1:0] base_ff, base_in, next_ff, next_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             pend_out_ff, pend_out_in;
   logic [2:0]       pend_seq_ff, pend_seq_in;
   logic [PW-1:0]    pend_data_ff, pend_data_in;
   timer_type        pend_timer_ff, pend_timer_in;
   logic             pend_acc_ff, pend_acc_in;

   logic             out_pkt_ff;
   logic [2:0]       out_seq_ff;
   logic [PW-1:0]    out_data_ff;
   timer_type        out_timer_ff;
   logic             out_acc_ff;
   logic             out_full_ff;
   logic [2:0]       out_base_ff;
   logic [2:0]       out_cnt_ff;

   logic [CW-1:0]    seq_w, base_w, next_w, cnt_w, off, inv_sum;
   logic             in_range, hit, hit_acked, live, full, accept, shift, publish;
   logic [CAP-1:0]   match, load_vec, mark_vec, acked_vec;
   logic [PW-1:0]    hit_data, wr_data;
   logic [PW-1:0]    cell_data [CAP];
   op_type           op;

   assign op      = op_type'(req_op);
   assign seq_w   = CW'(req_seq_number);
   assign base_w  = CW'(base_ff);
   assign next_w  = CW'(next_ff);
   assign cnt_w   = CW'(cnt_ff);
   assign full    = (cnt_ff == CNT_W'(CAP));
   assign wr_data = PW'(req_message_word);

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign shift     = (state_ff == ST_SLIDE) && (cnt_ff != '0) && acked_vec[0];
   assign publish   = (state_ff == ST_SLIDE) && !shift && (!rsp_valid_ff || rsp_ready);

   // offset of the named sequence number from the base
   always_comb begin
      in_range = seq_w < CW'(SEQ_SPACE);
      off      = seq_w - base_w;
      if (seq_w < base_w) begin
         off = off + CW'(SEQ_SPACE);
      end
      hit = in_range && (off < cnt_w);
   end

   always_comb begin
      hit_acked = 1'b0;
      hit_data  = '0;
      for (int i = 0; i < CAP; i++) begin
         match[i]    = hit && (off == CW'(i));
         hit_acked   = hit_acked | (match[i] & acked_vec[i]);
         hit_data    = hit_data | (cell_data[i] & {PW{match[i]}});
         load_vec[i] = accept && (op == OP_SEND) && !full && (cnt_ff == CNT_W'(i));
      end
   end

   assign live = hit && !hit_acked;

   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         mark_vec[i] = accept && (op == OP_ACK) && req_check_ok && live && match[i];
      end
   end

   for (genvar g = 0; g < CAP; g++) begin : g_cell
      cell_ctrl_type ctrl;
      logic [PW-1:0] nb_data;
      logic          nb_acked;

      assign ctrl.shift = shift;
      assign ctrl.load  = load_vec[g];
      assign ctrl.mark  = mark_vec[g];

      if (g == CAP - 1) begin : g_tail
         assign nb_data  = cell_data[g];
         assign nb_acked = 1'b0;
      end else begin : g_body
         assign nb_data  = cell_data[g+1];
         assign nb_acked = acked_vec[g+1];
      end

      srsw_cell #(
         .PW(PW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_data  (wr_data),
         .nb_data  (nb_data),
         .nb_acked (nb_acked),
         .data     (cell_data[g]),
         .acked    (acked_vec[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SLIDE;
               if ((op == OP_SEND) && !full) begin
                  cnt_in  = cnt_ff + CNT_W'(1);
                  next_in = (next_ff == SEQ_W'(SEQ_SPACE - 1)) ? '0 : next_ff + SEQ_W'(1);
               end
            end
         end
         ST_SLIDE: begin
            if (shift) begin
               cnt_in  = cnt_ff - CNT_W'(1);
               base_in = (base_ff == SEQ_W'(SEQ_SPACE - 1)) ? '0 : base_ff + SEQ_W'(1);
            end else if (publish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         next_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result of the event, held while the row slides
   always_comb begin
      pend_out_in   = 1'b0;
      pend_data_in  = '0;
      pend_timer_in = TMR_NONE;
      pend_acc_in   = 1'b0;
      pend_seq_in   = req_seq_number;
      case (op)
         OP_SEND: begin
            pend_seq_in = next_w[2:0];
            if (!full) begin
               pend_out_in   = 1'b1;
               pend_data_in  = wr_data;
               pend_timer_in = TMR_START;
               pend_acc_in   = 1'b1;
            end
         end
         OP_ACK: begin
            if (req_check_ok && live) begin
               pend_timer_in = TMR_STOP;
               pend_acc_in   = 1'b1;
            end
         end
         OP_TIMEOUT: begin
            if (live) begin
               pend_out_in   = 1'b1;
               pend_data_in  = hit_data;
               pend_timer_in = TMR_RESTART;
               pend_acc_in   = 1'b1;
            end
         end
         default: pend_seq_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_out_ff   <= pend_out_in;
         pend_seq_ff   <= pend_seq_in;
         pend_data_ff  <= pend_data_in;
         pend_timer_ff <= pend_timer_in;
         pend_acc_ff   <= pend_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (publish) begin
         out_pkt_ff   <= pend_out_ff;
         out_seq_ff   <= pend_seq_ff;
         out_data_ff  <= pend_data_ff;
         out_timer_ff <= pend_timer_ff;
         out_acc_ff   <= pend_acc_ff;
         out_full_ff  <= full;
         out_base_ff  <= base_w[2:0];
         out_cnt_ff   <= cnt_w[2:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packet_out   = out_pkt_ff;
   assign rsp_packet_seq   = out_seq_ff;
   assign rsp_packet_data  = 32'(out_data_ff);
   assign rsp_timer_action = out_timer_ff;
   assign rsp_accepted     = out_acc_ff;
   assign rsp_window_full  = out_full_ff;
   assign rsp_window_base  = out_base_ff;
   assign rsp_outstanding  = out_cnt_ff;

   // base plus outstanding count wraps to the next sequence number
   always_comb begin
      inv_sum = base_w + cnt_w;
      if (inv_sum >= CW'(SEQ_SPACE)) begin
         inv_sum = inv_sum - CW'(SEQ_SPACE);
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAP))
      else $error("outstanding count exceeds window capacity");

   a_seq_track: assert property (@(posedge clock) disable iff (reset)
      inv_sum == next_w)
      else $error("base and count out of step with next sequence number");

   a_pkt_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_out |-> rsp_accepted)
      else $error("packet emitted without the event being accepted");

   a_shift_slide: assert property (@(posedge clock) disable iff (reset)
      shift |=> state_ff == ST_SLIDE)
      else $error("row shift ended the slide too early");

endmodule

### sv/srsw_cell.sv
module srsw_cell #(
   parameter int PW = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srsw_pkg::cell_ctrl_type ctrl,
   input  logic [PW-1:0]          wr_data,
   input  logic [PW-1:0]          nb_data,
   input  logic                   nb_acked,
   output logic [PW-1:0]          data,
   output logic                   acked
);
   import srsw_pkg::*;

   logic [PW-1:0] data_ff, data_in;
   logic          acked_ff, acked_in;

   always_comb begin
      data_in  = data_ff;
      acked_in = acked_ff;
      if (ctrl.shift) begin
         data_in  = nb_data;
         acked_in = nb_acked;
      end else if (ctrl.load) begin
         data_in  = wr_data;
         acked_in = 1'b0;
      end else if (ctrl.mark) begin
         acked_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         acked_ff <= 1'b0;
      end else begin
         acked_ff <= acked_in;
      end
   end

   assign data  = data_ff;
   assign acked = acked_ff;

endmodule
